// ===== hw/rtl/cd_pkg.sv =====
// ----------------------------------------------------------------------------
// cd_pkg: shared types and constants for the circular deque
// Holds the transaction payload structs, operation and status codes, and
// the control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cd_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int DATA_W        = 32;

  // Operation codes carried in the action field.
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [1:0] ACT_PUSH_REAR  = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_REAR   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_RESERVED   = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic                     now_empty;
    logic                     now_full;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the input transaction, update indices and store
    logic load_out;  // move the finished result into the output register
  } cd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a result that is being stalled
  } cd_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit words in a circular store
// A result is registered in the store read and pending registers when its
// transaction is accepted, then loaded into the output register. A new
// transaction is not taken until the current one has loaded its result.
// Reset (rst_n low, synchronous): the deque is empty, both indices are zero
// and no result is pending. Store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
  // Number of words the deque can hold (2 to 65536).
  parameter int DEPTH = cd_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // Input channel: one operation per transaction.
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cd_pkg::in_item_t in_data,
  // Result channel: exactly one result per accepted transaction.
  output logic               out_valid,
  input  wire logic          out_stall,
  output cd_pkg::out_item_t  out_data
);

  // The controller sequences each transaction in two steps: the accept
  // step updates the front and rear indices, writes the store for a push and
  // reads it (the word is kept only for a pop); the finish step waits for the output
  // register to be free and loads the result into it. Because the result
  // sits in its own register, a new transaction is taken as soon as the
  // finish step completes, even if the downstream side is still stalling
  // the previous result.
  cd_pkg::cd_cmd_t cmd;
  cd_pkg::cd_sts_t sts;

  cd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps the indices, the empty flag, the entry store and
  // the output register. Pushes into a full deque and pops from an empty
  // deque leave all state unchanged and report a status code instead.
  cd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cd_ctrl: operation sequencer for the circular deque
// Accepts one transaction, waits for the store read, then hands the result
// to the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire cd_pkg::cd_sts_t sts,
  output cd_pkg::cd_cmd_t   cmd
);

  localparam logic STATE_IDLE = 1'b0;
  localparam logic STATE_FIN  = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      STATE_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = STATE_FIN;
        end
      end
      STATE_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = STATE_IDLE;
        end
      end
      default: state_nxt = STATE_IDLE;
    endcase
  end

  assign in_stall = (state_r != STATE_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cd_dpath.sv =====
// ----------------------------------------------------------------------------
// cd_dpath: index registers, entry store and output register of the deque
// Computes the next front and rear indices, writes or reads the store, and
// holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_dpath #(
  parameter int DEPTH = cd_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cd_pkg::in_item_t in_data,
  input  wire cd_pkg::cd_cmd_t  cmd,
  output cd_pkg::cd_sts_t    sts,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cd_pkg::out_item_t  out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ZERO = '0;

  logic signed [cd_pkg::DATA_W-1:0] store_mem [DEPTH];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;

  logic [1:0]       pend_status_r;
  logic             pend_empty_r;
  logic             pend_full_r;
  logic             pend_pop_r;
  logic signed [cd_pkg::DATA_W-1:0] rd_data_r;

  logic             out_valid_r;
  cd_pkg::out_item_t out_data_r;

  logic             full_now;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             pop_ok;
  logic [1:0]       status_nxt;

  function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] idx);
    wrap_up = (idx == IDX_LAST) ? IDX_ZERO : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] idx);
    wrap_down = (idx == IDX_ZERO) ? IDX_LAST : idx - IDX_W'(1);
  endfunction

  assign full_now = !empty_r && (wrap_up(tail_r) == head_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    wr_en      = 1'b0;
    wr_addr    = IDX_ZERO;
    pop_ok     = 1'b0;
    status_nxt = cd_pkg::ST_DONE;
    rd_addr    = (in_data.action == cd_pkg::ACT_POP_FRONT) ? head_r : tail_r;
    unique case (in_data.action)
      cd_pkg::ACT_PUSH_FRONT, cd_pkg::ACT_PUSH_REAR: begin
        if (full_now) begin
          status_nxt = cd_pkg::ST_FULL;
        end else if (empty_r) begin
          head_nxt  = IDX_ZERO;
          tail_nxt  = IDX_ZERO;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = IDX_ZERO;
        end else if (in_data.action == cd_pkg::ACT_PUSH_FRONT) begin
          head_nxt = wrap_down(head_r);
          wr_en    = 1'b1;
          wr_addr  = wrap_down(head_r);
        end else begin
          tail_nxt = wrap_up(tail_r);
          wr_en    = 1'b1;
          wr_addr  = wrap_up(tail_r);
        end
      end
      cd_pkg::ACT_POP_FRONT, cd_pkg::ACT_POP_REAR: begin
        if (empty_r) begin
          status_nxt = cd_pkg::ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
          if (head_r == tail_r) begin
            head_nxt  = IDX_ZERO;
            tail_nxt  = IDX_ZERO;
            empty_nxt = 1'b1;
          end else if (in_data.action == cd_pkg::ACT_POP_FRONT) begin
            head_nxt = wrap_up(head_r);
          end else begin
            tail_nxt = wrap_down(tail_r);
          end
        end
      end
      default: status_nxt = cd_pkg::ST_RESERVED;
    endcase
  end

  // Entry store: at most one write and one registered read per accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      store_mem[wr_addr] <= in_data.push_value;
    end
    if (cmd.accept) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= IDX_ZERO;
      tail_r  <= IDX_ZERO;
      empty_r <= 1'b1;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status_r <= status_nxt;
      pend_empty_r  <= empty_nxt;
      pend_full_r   <= !empty_nxt && (wrap_up(tail_nxt) == head_nxt);
      pend_pop_r    <= pop_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.pop_value <= pend_pop_r ? rd_data_r : '0;
      out_data_r.status    <= pend_status_r;
      out_data_r.now_empty <= pend_empty_r;
      out_data_r.now_full  <= pend_full_r;
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cd_checker.sv =====
// ----------------------------------------------------------------------------
// cd_checker: port-level assertions for the circular deque
// Watches the result channel for consistent status and flag combinations.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire cd_pkg::out_item_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A result with a rejection status carries a zero word.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != cd_pkg::ST_DONE) |-> out_data.pop_value == '0)
    else $error("rejected transaction carries a nonzero word");

  // The deque cannot be empty and full at once.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.now_empty && out_data.now_full))
    else $error("empty and full reported together");

  // A push rejected as full leaves the deque full; a pop rejected as empty
  // leaves it empty.
  a_reject_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.status != cd_pkg::ST_FULL) || out_data.now_full) &&
                  ((out_data.status != cd_pkg::ST_EMPTY) || out_data.now_empty))
    else $error("rejection status disagrees with flags");

  // No result appears without a transaction having been accepted.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pending transaction");

endmodule

bind circular_deque cd_checker u_cd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/tb_circular_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque: self-checking testbench for the circular deque
// A short table of directed transactions covers the empty and one-entry
// corners and the extreme words. Long random phases then fill the deque
// until pushes are refused, drain it until pops are refused, and mix both.
// Every result is checked field by field against a behavioral mirror of
// the deque or a hand-written result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_circular_deque;

  localparam int DEPTH          = cd_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS   = 1200;
  // Cycles run after the last owed result before the end, to catch strays.
  localparam int DRAIN_CYCLES   = 10;
  // The longest correct quiet spell is one sender gap plus one receiver stall
  // plus the result path. The limit is far above it.
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  // One row of the directed table. When has_exp is set, the row carries a
  // result typed in by hand, which replaces the mirror's prediction.
  typedef struct packed {
    cd_pkg::in_item_t  op;
    logic              has_exp;
    cd_pkg::out_item_t exp;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  cd_pkg::in_item_t  in_data;
  logic              out_valid;
  logic              out_stall;
  cd_pkg::out_item_t out_data;

  // A hand-written result travels next to the transaction it belongs to.
  logic              typed_valid;
  cd_pkg::out_item_t typed_result;

  // Mirror of the deque contents: front of the deque is index 0.
  logic signed [cd_pkg::DATA_W-1:0] deque_words[$];
  // Results that the DUT still owes us, oldest first.
  cd_pkg::out_item_t                pending_results[$];
  stim_row_t                        directed_rows[$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  circular_deque #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Applies one operation to the mirror and returns the result the DUT
  // must produce for it. A refused push or pop leaves the mirror untouched.
  function automatic cd_pkg::out_item_t apply_deque_op(cd_pkg::in_item_t op);
    cd_pkg::out_item_t r;
    r = '0;
    r.status = cd_pkg::ST_DONE;
    case (op.action)
      cd_pkg::ACT_PUSH_FRONT, cd_pkg::ACT_PUSH_REAR: begin
        if (deque_words.size() >= DEPTH) begin
          r.status = cd_pkg::ST_FULL;
        end else if (op.action == cd_pkg::ACT_PUSH_FRONT) begin
          deque_words.push_front(op.push_value);
        end else begin
          deque_words.push_back(op.push_value);
        end
      end
      cd_pkg::ACT_POP_FRONT, cd_pkg::ACT_POP_REAR: begin
        if (deque_words.size() == 0) begin
          r.status = cd_pkg::ST_EMPTY;
        end else if (op.action == cd_pkg::ACT_POP_FRONT) begin
          r.pop_value = deque_words.pop_front();
        end else begin
          r.pop_value = deque_words.pop_back();
        end
      end
    endcase
    r.now_empty = (deque_words.size() == 0);
    r.now_full  = (deque_words.size() == DEPTH);
    return r;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Mostly random words, with the extremes and the all-zero and all-one
  // patterns mixed in so that they show up in every phase.
  function automatic logic signed [cd_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return 32'shFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cd_pkg::out_item_t result_of(
      logic signed [cd_pkg::DATA_W-1:0] pop_value, logic [1:0] status,
      logic now_empty, logic now_full);
    cd_pkg::out_item_t r;
    r.pop_value = pop_value;
    r.status    = status;
    r.now_empty = now_empty;
    r.now_full  = now_full;
    return r;
  endfunction

  task automatic add_row(logic [1:0] action, logic signed [cd_pkg::DATA_W-1:0] value,
                         logic has_exp, cd_pkg::out_item_t exp);
    stim_row_t row;
    row.op.action     = action;
    row.op.push_value = value;
    row.has_exp       = has_exp;
    row.exp           = exp;
    directed_rows.push_back(row);
  endtask

  // Presents one transaction after an idle gap and holds it until the DUT
  // takes it. The valid line is never dropped and raised in the same step:
  // with no gap, the next transaction simply follows on the same edge.
  task automatic send_op(cd_pkg::in_item_t op, logic has_exp, cd_pkg::out_item_t exp,
                         int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= op;
    typed_valid  <= has_exp;
    typed_result <= exp;
    do @(posedge clk); while (in_stall);
  endtask

  // Monitor. Processes woken by the clock edge see the values from before
  // the edge, so acceptance on both channels is judged without races.
  // An input transaction is predicted when it is taken; a result transaction
  // is compared with the oldest prediction when it is taken.
  always @(posedge clk) begin : monitor
    cd_pkg::out_item_t predicted;
    cd_pkg::out_item_t want;
    logic              taken_any;
    taken_any = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        taken_any = 1'b1;
        predicted = apply_deque_op(in_data);
        pending_results.push_back(typed_valid ? typed_result : predicted);
      end
      if (out_valid && !out_stall) begin
        taken_any = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected: pop_value %0d status %0d",
                 out_data.pop_value, out_data.status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.pop_value !== want.pop_value) begin
            $error("pop_value: expected %0d, got %0d", want.pop_value, out_data.pop_value);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.now_empty !== want.now_empty) begin
            $error("now_empty: expected %0b, got %0b", want.now_empty, out_data.now_empty);
            error_count++;
          end
          if (out_data.now_full !== want.now_full) begin
            $error("now_full: expected %0b, got %0b", want.now_full, out_data.now_full);
            error_count++;
          end
        end
      end
    end
    idle_cycles <= taken_any ? 0 : idle_cycles + 1;
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side back-pressure. Short free runs alternate with stalls; now
  // and then a long free run lets the DUT stream at full rate.
  initial begin : result_stall
    int unsigned free_run;
    int unsigned stall_len;
    out_stall <= 1'b0;
    forever begin
      free_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 8);
      stall_len = pick_gap();
      out_stall <= 1'b0;
      repeat (free_run) @(posedge clk);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    cd_pkg::in_item_t op;
    phase_kind_t      kind;
    int unsigned      phase_idx;
    int unsigned      phase_len;
    int unsigned      push_pct;
    int unsigned      items_sent;
    logic             calm;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    typed_valid  <= 1'b0;
    typed_result <= '0;

    // Directed part. After reset the deque is empty, so both pops are
    // refused. A single entry can be removed from either end, and removing
    // it empties the deque again. The longer sequence checks the ordering
    // of front and rear pushes through the mirror.
    add_row(cd_pkg::ACT_POP_FRONT,  32'sd0, 1'b1,
            result_of(32'sd0, cd_pkg::ST_EMPTY, 1'b1, 1'b0));
    add_row(cd_pkg::ACT_POP_REAR,   32'sh1234_5678, 1'b1,
            result_of(32'sd0, cd_pkg::ST_EMPTY, 1'b1, 1'b0));
    add_row(cd_pkg::ACT_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1,
            result_of(32'sd0, cd_pkg::ST_DONE, 1'b0, 1'b0));
    add_row(cd_pkg::ACT_POP_REAR,   32'sd0, 1'b1,
            result_of(32'sh7FFF_FFFF, cd_pkg::ST_DONE, 1'b1, 1'b0));
    add_row(cd_pkg::ACT_PUSH_REAR,  32'sh8000_0000, 1'b1,
            result_of(32'sd0, cd_pkg::ST_DONE, 1'b0, 1'b0));
    add_row(cd_pkg::ACT_POP_FRONT,  32'shFFFF_FFFF, 1'b1,
            result_of(32'sh8000_0000, cd_pkg::ST_DONE, 1'b1, 1'b0));
    add_row(cd_pkg::ACT_PUSH_REAR,  32'shFFFF_FFFF, 1'b1,
            result_of(32'sd0, cd_pkg::ST_DONE, 1'b0, 1'b0));
    add_row(cd_pkg::ACT_PUSH_FRONT, 32'sd0,          1'b0, '0);
    add_row(cd_pkg::ACT_PUSH_FRONT, 32'sd1,          1'b0, '0);
    add_row(cd_pkg::ACT_PUSH_REAR,  32'sh5555_5555,  1'b0, '0);
    add_row(cd_pkg::ACT_PUSH_REAR,  32'shAAAA_AAAA,  1'b0, '0);
    add_row(cd_pkg::ACT_POP_FRONT,  32'sh0F0F_0F0F,  1'b0, '0);
    add_row(cd_pkg::ACT_POP_REAR,   32'shF0F0_F0F0,  1'b0, '0);
    add_row(cd_pkg::ACT_POP_FRONT,  32'sd0,          1'b0, '0);
    add_row(cd_pkg::ACT_POP_FRONT,  32'sd0,          1'b0, '0);
    add_row(cd_pkg::ACT_POP_REAR,   32'sd0,          1'b0, '0);
    add_row(cd_pkg::ACT_POP_REAR,   32'sd0, 1'b1,
            result_of(32'sd0, cd_pkg::ST_EMPTY, 1'b1, 1'b0));
    add_row(cd_pkg::ACT_PUSH_FRONT, 32'sh0F0F_0F0F,  1'b0, '0);
    add_row(cd_pkg::ACT_PUSH_FRONT, 32'shF0F0_F0F0,  1'b0, '0);
    add_row(cd_pkg::ACT_POP_REAR,   32'sd0,          1'b0, '0);
    add_row(cd_pkg::ACT_POP_REAR,   32'sd0,          1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].has_exp, directed_rows[i].exp,
              pick_gap());

    // Random part, in phases. The first phase fills the deque past full and
    // the second drains it past empty, so both refusals show up early; after
    // that the phase kinds are drawn at random. Fill and drain phases carry
    // a little noise from the opposite direction; mixed phases balance pushes
    // and pops and walk the indices around the circular store.
    phase_idx  = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase_idx == 0) begin
        kind = PH_FILL;
      end else if (phase_idx == 1) begin
        kind = PH_DRAIN;
      end else begin
        case ($urandom_range(0, 3))
          0:       kind = PH_FILL;
          1:       kind = PH_DRAIN;
          default: kind = PH_MIXED;
        endcase
      end
      case (kind)
        PH_FILL: begin
          push_pct  = (phase_idx == 0) ? 100 : 95;
          phase_len = DEPTH + DEPTH / 4;
        end
        PH_DRAIN: begin
          push_pct  = (phase_idx == 1) ? 0 : 5;
          phase_len = DEPTH + DEPTH / 4;
        end
        default: begin
          push_pct  = $urandom_range(35, 65);
          phase_len = $urandom_range(40, 150);
        end
      endcase
      // The last phase stops at the planned transaction count.
      if (phase_len > RANDOM_ITEMS - items_sent)
        phase_len = RANDOM_ITEMS - items_sent;
      // Some phases run back to back with no idle cycles on the input side.
      calm = ($urandom_range(0, 4) == 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct)
          op.action = $urandom_range(0, 1) ? cd_pkg::ACT_PUSH_FRONT
                                           : cd_pkg::ACT_PUSH_REAR;
        else
          op.action = $urandom_range(0, 1) ? cd_pkg::ACT_POP_FRONT
                                           : cd_pkg::ACT_POP_REAR;
        // Pops carry a random word as well; the DUT must ignore it.
        op.push_value = pick_word();
        send_op(op, 1'b0, '0, calm ? 0 : pick_gap());
        items_sent++;
      end
      phase_idx++;
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then wait DRAIN_CYCLES more to catch strays.
    // A result that never comes is caught by the watchdog.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
